>>> src/rmrd_pkg.sv
`timescale 1ns / 1ps

package rmrd_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int CFG_W  = 13;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [7:0] CODE_IMAGE_END = 8'h00;
    localparam logic [7:0] CODE_ROW_END   = 8'h80;

    localparam logic [ADDR_W-3:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [ADDR_W-3:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        KIND_PIXEL     = 2'd0,
        KIND_ROW_END   = 2'd1,
        KIND_IMAGE_END = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_CODE   = 2'd0,
        PH_REPEAT = 2'd1,
        PH_ENUM   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        SQ_IDLE   = 2'd0,
        SQ_DECODE = 2'd1,
        SQ_RUN    = 2'd2
    } seq_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       first;
    } code_t;

    typedef struct packed {
        kind_t       kind;
        logic [11:0] row;
        logic [11:0] column;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic        last;
    } pix_t;

    typedef struct packed {
        logic [CFG_W-1:0] image_width;
        logic [CFG_W-1:0] image_height;
    } cfg_t;

endpackage

>>> src/rmrd_cfg_regs.sv
`timescale 1ns / 1ps

module rmrd_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rmrd_pkg::ADDR_W-1:0]  paddr,
    input  logic [rmrd_pkg::DATA_W-1:0]  pwdata,
    output logic [rmrd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output rmrd_pkg::cfg_t               cfg
);
    import rmrd_pkg::*;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             wr_en;
    logic [ADDR_W-3:0] idx;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
        end
        else if (wr_en)
        begin
            case (idx)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_IMAGE_WIDTH:  prdata = DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.image_width  = width_reg;
    assign cfg.image_height = height_reg;

endmodule

>>> src/rmrd_room_clamp.sv
`timescale 1ns / 1ps

module rmrd_room_clamp #(
    parameter int CW = 13,
    parameter int EW = 13
) (
    input  logic [CW-1:0] column,
    input  logic [EW-1:0] width_eff,
    input  logic [6:0]    count,
    output logic [6:0]    kept
);
    logic [EW-1:0] col_ext;
    logic [EW-1:0] room;

    assign col_ext = EW'(column);
    assign room    = (col_ext >= width_eff) ? '0 : width_eff - col_ext;
    assign kept    = (EW'(count) < room) ? count : room[6:0];

endmodule

>>> src/rgb_mask_rle_decoder_core.sv
// Flow: an accepted byte is decoded in the following cycle; a row end, image end or
// enumerated pixel is registered to the output while decoding, once the output slot is
// free, and the pixels of a repeat run follow from the run state after its red byte.
// No new byte is accepted while a byte is decoded or a repeat run is emitted
// (code_stall); an output stall holds either one.
// Reset: asynchronous active-low; width and height reset to 1, decoder at row 0.
`timescale 1ns / 1ps

module rgb_mask_rle_decoder_core #(
    parameter int MAX_WIDTH  = rmrd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rmrd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         code_valid,
    output logic                         code_stall,
    input  rmrd_pkg::code_t              code_item,
    output logic                         pix_valid,
    input  logic                         pix_stall,
    output rmrd_pkg::pix_t               pix_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rmrd_pkg::ADDR_W-1:0]  paddr,
    input  logic [rmrd_pkg::DATA_W-1:0]  pwdata,
    output logic [rmrd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import rmrd_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int EW  = (CW > CFG_W) ? CW : CFG_W;
    localparam int EHW = (RW > CFG_W) ? RW : CFG_W;

    cfg_t cfg;

    seq_t          state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [6:0]    remaining_reg, remaining_next;
    logic [6:0]    kept_reg, kept_next;
    logic [1:0]    bidx_reg, bidx_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic          finished_reg, finished_next;
    logic          out_valid_reg, out_valid_next;

    logic [7:0]    byte_reg, byte_next;
    logic [7:0]    blue_hold_reg, blue_hold_next;
    logic [7:0]    green_hold_reg, green_hold_next;
    logic [7:0]    red_hold_reg, red_hold_next;
    pix_t          out_reg, out_next;

    logic [EW-1:0]  width_eff;
    logic [EHW-1:0] height_eff;
    logic [EW-1:0]  col_ext;
    logic [EHW-1:0] row_ext;
    logic [RW-1:0]  row_inc;
    logic [CW-1:0]  col_inc;
    logic [6:0]     clamp_in;
    logic [6:0]     clamp_out;
    logic           slot_free;
    logic           accept;
    logic [6:0]     rem_dec;

    rmrd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign width_eff  = (EW'(cfg.image_width) > EW'(MAX_WIDTH))
                        ? EW'(MAX_WIDTH) : EW'(cfg.image_width);
    assign height_eff = (EHW'(cfg.image_height) > EHW'(MAX_HEIGHT))
                        ? EHW'(MAX_HEIGHT) : EHW'(cfg.image_height);

    assign clamp_in = byte_reg[7] ? {1'b0, byte_reg[5:0]} : byte_reg[6:0];

    rmrd_room_clamp #(
        .CW (CW),
        .EW (EW)
    ) u_clamp (
        .column    (col_reg),
        .width_eff (width_eff),
        .count     (clamp_in),
        .kept      (clamp_out)
    );

    assign col_ext   = EW'(col_reg);
    assign row_ext   = EHW'(row_reg);
    assign row_inc   = row_reg + RW'(1);
    assign col_inc   = col_reg + CW'(1);
    assign rem_dec   = (remaining_reg != 7'd0) ? remaining_reg - 7'd1 : 7'd0;
    assign slot_free = !out_valid_reg || !pix_stall;
    assign accept    = code_valid && !code_stall;

    assign code_stall = (state_reg != SQ_IDLE);
    assign pix_valid  = out_valid_reg;
    assign pix_item   = out_reg;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        remaining_next  = remaining_reg;
        kept_next       = kept_reg;
        bidx_next       = bidx_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        finished_next   = finished_reg;
        byte_next       = byte_reg;
        blue_hold_next  = blue_hold_reg;
        green_hold_next = green_hold_reg;
        red_hold_next   = red_hold_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && pix_stall;

        case (state_reg)
            SQ_IDLE:
            begin
                if (accept)
                begin
                    byte_next  = code_item.code_byte;
                    state_next = SQ_DECODE;
                    if (code_item.first)
                    begin
                        phase_next     = PH_CODE;
                        remaining_next = '0;
                        kept_next      = '0;
                        bidx_next      = '0;
                        row_next       = '0;
                        col_next       = '0;
                        finished_next  = 1'b0;
                    end
                end
            end

            SQ_DECODE:
            begin
                if (finished_reg || row_ext >= height_eff)
                begin
                    state_next = SQ_IDLE;
                end
                else if (phase_reg == PH_CODE)
                begin
                    if (byte_reg == CODE_IMAGE_END)
                    begin
                        if (slot_free)
                        begin
                            out_next       = '0;
                            out_next.kind  = KIND_IMAGE_END;
                            out_next.row   = row_ext[11:0];
                            out_next.last  = 1'b1;
                            out_valid_next = 1'b1;
                            finished_next  = 1'b1;
                            state_next     = SQ_IDLE;
                        end
                    end
                    else if (byte_reg == CODE_ROW_END)
                    begin
                        if (slot_free)
                        begin
                            out_next       = '0;
                            out_next.kind  = KIND_ROW_END;
                            out_next.row   = row_ext[11:0];
                            out_next.last  = 1'b1;
                            out_valid_next = 1'b1;
                            row_next       = row_inc;
                            col_next       = '0;
                            finished_next  = (EHW'(row_inc) >= height_eff);
                            state_next     = SQ_IDLE;
                        end
                    end
                    else if (byte_reg[7])
                    begin
                        if (byte_reg[6])
                        begin
                            col_next = col_reg + CW'(clamp_out);
                        end
                        else
                        begin
                            phase_next = PH_REPEAT;
                            kept_next  = clamp_out;
                            bidx_next  = '0;
                        end
                        state_next = SQ_IDLE;
                    end
                    else
                    begin
                        phase_next     = PH_ENUM;
                        remaining_next = byte_reg[6:0];
                        kept_next      = clamp_out;
                        bidx_next      = '0;
                        state_next     = SQ_IDLE;
                    end
                end
                else
                begin
                    case (bidx_reg)
                        2'd0:
                        begin
                            blue_hold_next = byte_reg;
                            bidx_next      = 2'd1;
                            state_next     = SQ_IDLE;
                        end
                        2'd1:
                        begin
                            green_hold_next = byte_reg;
                            bidx_next       = 2'd2;
                            state_next      = SQ_IDLE;
                        end
                        default:
                        begin
                            if (phase_reg == PH_REPEAT)
                            begin
                                bidx_next     = '0;
                                red_hold_next = byte_reg;
                                phase_next    = PH_CODE;
                                state_next    = (kept_reg != 7'd0) ? SQ_RUN : SQ_IDLE;
                            end
                            else if (kept_reg != 7'd0)
                            begin
                                if (slot_free)
                                begin
                                    out_next.kind   = KIND_PIXEL;
                                    out_next.row    = row_ext[11:0];
                                    out_next.column = col_ext[11:0];
                                    out_next.blue   = blue_hold_reg;
                                    out_next.green  = green_hold_reg;
                                    out_next.red    = byte_reg;
                                    out_next.last   = 1'b1;
                                    out_valid_next  = 1'b1;
                                    col_next        = col_inc;
                                    kept_next       = kept_reg - 7'd1;
                                    remaining_next  = rem_dec;
                                    bidx_next       = '0;
                                    if (rem_dec == 7'd0)
                                    begin
                                        phase_next = PH_CODE;
                                    end
                                    state_next = SQ_IDLE;
                                end
                            end
                            else
                            begin
                                remaining_next = rem_dec;
                                bidx_next      = '0;
                                if (rem_dec == 7'd0)
                                begin
                                    phase_next = PH_CODE;
                                end
                                state_next = SQ_IDLE;
                            end
                        end
                    endcase
                end
            end

            SQ_RUN:
            begin
                if (slot_free)
                begin
                    out_next.kind   = KIND_PIXEL;
                    out_next.row    = row_ext[11:0];
                    out_next.column = col_ext[11:0];
                    out_next.blue   = blue_hold_reg;
                    out_next.green  = green_hold_reg;
                    out_next.red    = red_hold_reg;
                    out_next.last   = (kept_reg == 7'd1);
                    out_valid_next  = 1'b1;
                    col_next        = col_inc;
                    kept_next       = kept_reg - 7'd1;
                    if (kept_reg == 7'd1)
                    begin
                        state_next = SQ_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SQ_IDLE;
            phase_reg     <= PH_CODE;
            remaining_reg <= '0;
            kept_reg      <= '0;
            bidx_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            kept_reg      <= kept_next;
            bidx_reg      <= bidx_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        blue_hold_reg  <= blue_hold_next;
        green_hold_reg <= green_hold_next;
        red_hold_reg   <= red_hold_next;
        out_reg        <= out_next;
    end

`ifndef SYNTHESIS
    a_run_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SQ_RUN |-> kept_reg != 7'd0)
        else $error("repeat run entered with nothing left to emit");

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == SQ_DECODE)
        else $error("accepted item not decoded next cycle");

    a_column_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_ext <= EW'(MAX_WIDTH))
        else $error("column beyond maximum width");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_ext <= EHW'(MAX_HEIGHT))
        else $error("row beyond maximum height");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rmrd_pkg::*;

    localparam logic [7:0] RUN_FLAG   = 8'h80;
    localparam logic [7:0] SKIP_FLAG  = 8'h40;
    localparam logic [7:0] COUNT_MASK = 8'h3F;

    localparam logic [ADDR_W-1:0] WIDTH_ADDR  = ADDR_W'({REG_IMAGE_WIDTH, 2'b00});
    localparam logic [ADDR_W-1:0] HEIGHT_ADDR = ADDR_W'({REG_IMAGE_HEIGHT, 2'b00});

    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int ITEM_TARGET    = 120;

    localparam pix_t NO_PIX    = '0;
    localparam pix_t ROW0_DONE = '{KIND_ROW_END, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b1};
    localparam pix_t ROW1_DONE = '{KIND_ROW_END, 12'd1, 12'd0, 8'd0, 8'd0, 8'd0, 1'b1};
    localparam pix_t IMG0_DONE = '{KIND_IMAGE_END, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b1};

    typedef enum {STEP_BYTE, STEP_WIDTH, STEP_HEIGHT} step_t;

    typedef struct {
        step_t       op;
        logic [31:0] value;
        bit          first;
        bit          typed;
        pix_t        want;
    } plan_row_t;

    plan_row_t plan [37] = '{
        '{STEP_BYTE,   32'h80,   1'b0, 1'b1, ROW0_DONE},
        '{STEP_BYTE,   32'h00,   1'b1, 1'b1, IMG0_DONE},
        '{STEP_WIDTH,  32'd4,    1'b0, 1'b0, NO_PIX},
        '{STEP_HEIGHT, 32'd3,    1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h82,   1'b1, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h00,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'hFF,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h7F,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'hC1,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h02,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h01,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h02,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h03,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h04,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h05,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h06,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h80,   1'b0, 1'b1, ROW0_DONE},
        '{STEP_BYTE,   32'hBF,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'hAA,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h55,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'hFF,   1'b0, 1'b0, NO_PIX},
        '{STEP_WIDTH,  32'd0,    1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h81,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h11,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h22,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h33,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h80,   1'b0, 1'b1, ROW1_DONE},
        '{STEP_HEIGHT, 32'd0,    1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h80,   1'b1, 1'b0, NO_PIX},
        '{STEP_WIDTH,  32'h1FFF, 1'b0, 1'b0, NO_PIX},
        '{STEP_HEIGHT, 32'h1FFF, 1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'hBF,   1'b1, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h00,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'hFF,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h80,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h7F,   1'b0, 1'b0, NO_PIX},
        '{STEP_BYTE,   32'h80,   1'b1, 1'b1, ROW0_DONE}
    };

    logic                clk;
    logic                rst_n;
    logic                code_valid;
    logic                code_stall;
    code_t               code_item;
    logic                pix_valid;
    logic                pix_stall = 1'b0;
    pix_t                pix_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    logic [12:0] width_reg;
    logic [12:0] height_reg;
    phase_t      dec_phase;
    logic [6:0]  enum_left;
    logic [6:0]  keep_count;
    logic [1:0]  triple_pos;
    logic [7:0]  blue_hold;
    logic [7:0]  green_hold;
    logic [12:0] cur_row;
    logic [12:0] cur_col;
    bit          image_done;

    pix_t expected_pix[$];
    int   used_items;
    int   mismatches;
    int   idle_cycles;
    bit   calm;

    rgb_mask_rle_decoder_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_item  (code_item),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix_item   (pix_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [6:0] fit_in_row(input logic [6:0] n);
        int w;
        int room;
        w = (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_reg);
        room = (int'(cur_col) >= w) ? 0 : w - int'(cur_col);
        return (int'(n) < room) ? n : 7'(room);
    endfunction

    function automatic string show(input pix_t p);
        return $sformatf("kind=%0d row=%0d col=%0d b=%02h g=%02h r=%02h last=%0b",
                         p.kind, p.row, p.column, p.blue, p.green, p.red, p.last);
    endfunction

    task automatic clear_decoder();
        dec_phase  = PH_CODE;
        enum_left  = '0;
        keep_count = '0;
        triple_pos = '0;
        blue_hold  = '0;
        green_hold = '0;
        cur_row    = '0;
        cur_col    = '0;
        image_done = 1'b0;
    endtask

    task automatic push_result(input kind_t k, input logic [12:0] col, input logic [7:0] r);
        pix_t p;
        p.kind   = k;
        p.row    = cur_row[11:0];
        p.column = col[11:0];
        p.blue   = (k == KIND_PIXEL) ? blue_hold : 8'd0;
        p.green  = (k == KIND_PIXEL) ? green_hold : 8'd0;
        p.red    = r;
        p.last   = 1'b0;
        expected_pix.push_back(p);
    endtask

    task automatic decode_byte(input code_t c);
        int         before_n;
        int         lim_h;
        logic [7:0] b;
        pix_t       tail;
        before_n = expected_pix.size();
        b = c.code_byte;
        if (c.first)
            clear_decoder();
        lim_h = (height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(height_reg);
        if (!image_done && int'(cur_row) < lim_h)
        begin
            if (dec_phase == PH_CODE)
            begin
                if (b == CODE_IMAGE_END)
                begin
                    push_result(KIND_IMAGE_END, '0, '0);
                    image_done = 1'b1;
                end
                else if (b == CODE_ROW_END)
                begin
                    push_result(KIND_ROW_END, '0, '0);
                    cur_row++;
                    cur_col = '0;
                    if (int'(cur_row) >= lim_h)
                        image_done = 1'b1;
                end
                else if ((b & RUN_FLAG) != 0)
                begin
                    if ((b & SKIP_FLAG) != 0)
                        cur_col += fit_in_row(7'(b & COUNT_MASK));
                    else
                    begin
                        dec_phase  = PH_REPEAT;
                        keep_count = fit_in_row(7'(b & COUNT_MASK));
                        triple_pos = '0;
                    end
                end
                else
                begin
                    dec_phase  = PH_ENUM;
                    enum_left  = b[6:0];
                    keep_count = fit_in_row(b[6:0]);
                    triple_pos = '0;
                end
            end
            else if (triple_pos == 2'd0)
            begin
                blue_hold  = b;
                triple_pos = 2'd1;
            end
            else if (triple_pos == 2'd1)
            begin
                green_hold = b;
                triple_pos = 2'd2;
            end
            else
            begin
                triple_pos = 2'd0;
                if (dec_phase == PH_REPEAT)
                begin
                    while (keep_count > 0)
                    begin
                        push_result(KIND_PIXEL, cur_col, b);
                        cur_col++;
                        keep_count--;
                    end
                    dec_phase = PH_CODE;
                end
                else
                begin
                    if (keep_count > 0)
                    begin
                        push_result(KIND_PIXEL, cur_col, b);
                        cur_col++;
                        keep_count--;
                    end
                    if (enum_left > 0)
                        enum_left--;
                    if (enum_left == 0)
                        dec_phase = PH_CODE;
                end
            end
        end
        if (expected_pix.size() > before_n)
        begin
            tail = expected_pix.pop_back();
            tail.last = 1'b1;
            expected_pix.push_back(tail);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input bit f,
                             input bit typed = 1'b0, input pix_t want = '0);
        code_t c;
        int    n0;
        c.code_byte = b;
        c.first     = f;
        if (!calm && $urandom_range(99) < 8)
        begin
            code_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 40)
                @(posedge clk);
        end
        code_valid <= 1'b1;
        code_item  <= c;
        @(posedge clk);
        while (code_stall)
            @(posedge clk);
        used_items++;
        n0 = expected_pix.size();
        decode_byte(c);
        if (typed)
        begin
            while (expected_pix.size() > n0)
                void'(expected_pix.pop_back());
            expected_pix.push_back(want);
        end
    endtask

    task automatic settle();
        code_valid <= 1'b0;
        while (expected_pix.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == WIDTH_ADDR)
            width_reg = data[12:0];
        else if (addr == HEIGHT_ADDR)
            height_reg = data[12:0];
        @(posedge clk);
    endtask

    task automatic run_image(input int budget);
        int         sent;
        int         pick;
        int         triples;
        bit         fresh;
        logic [7:0] lead;
        fresh = ($urandom_range(3) != 0);
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(99);
            triples = 0;
            if (pick < 8)
            begin
                send_byte(8'($urandom), $urandom_range(3) == 0);
                sent++;
            end
            else
            begin
                if (pick < 22)
                    lead = CODE_ROW_END;
                else if (pick < 25)
                    lead = CODE_IMAGE_END;
                else if (pick < 40)
                    lead = RUN_FLAG | SKIP_FLAG
                         | 8'($urandom_range(0, ($urandom_range(3) == 0) ? 63 : 6));
                else if (pick < 65)
                begin
                    lead = RUN_FLAG | 8'($urandom_range(1, ($urandom_range(3) == 0) ? 63 : 6));
                    triples = 1;
                end
                else
                begin
                    lead = 8'($urandom_range(1, ($urandom_range(15) == 0) ? 127 : 5));
                    triples = (lead > 5) ? 5 : int'(lead);
                end
                send_byte(lead, fresh);
                fresh = 1'b0;
                repeat (3 * triples)
                    send_byte(8'($urandom), 1'b0);
                sent += 1 + 3 * triples;
            end
        end
    endtask

    always @(posedge clk)
    begin
        pix_t want;
        if (rst_n && pix_valid && !pix_stall)
        begin
            if (expected_pix.size() == 0)
            begin
                if (mismatches < 10)
                    $display("Unexpected result: %s", show(pix_item));
                mismatches++;
            end
            else
            begin
                want = expected_pix.pop_front();
                if (pix_item.kind !== want.kind || pix_item.row !== want.row
                    || pix_item.column !== want.column || pix_item.blue !== want.blue
                    || pix_item.green !== want.green || pix_item.red !== want.red
                    || pix_item.last !== want.last)
                begin
                    if (mismatches < 10)
                        $display("Mismatch: expected %s, got %s", show(want), show(pix_item));
                    mismatches++;
                end
            end
        end
        if ((code_valid && !code_stall) || (pix_valid && !pix_stall) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        pix_stall <= rst_n && !calm && ($urandom_range(99) < 8);
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int         phase_no;
        logic [31:0] value;
        rst_n      <= 1'b0;
        code_valid <= 1'b0;
        code_item  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        width_reg  = 13'd1;
        height_reg = 13'd1;
        clear_decoder();
        used_items   = 0;
        calm         = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            case (plan[i].op)
                STEP_WIDTH:
                begin
                    settle();
                    write_reg(WIDTH_ADDR, plan[i].value);
                end
                STEP_HEIGHT:
                begin
                    settle();
                    write_reg(HEIGHT_ADDR, plan[i].value);
                end
                default:
                    send_byte(plan[i].value[7:0], plan[i].first, plan[i].typed, plan[i].want);
            endcase
        end

        phase_no = 0;
        while (used_items < ITEM_TARGET)
        begin
            settle();
            calm = (phase_no == 2 || phase_no == 3);
            if (phase_no == 0 || $urandom_range(1) == 1)
            begin
                case ($urandom_range(9))
                    0:       value = 32'd0;
                    1:       value = 32'd4096;
                    2:       value = 32'($urandom_range(4097, 8191));
                    default: value = 32'($urandom_range(1, 12));
                endcase
                if ($urandom_range(3) == 0)
                    value |= $urandom & ~32'h1FFF;
                write_reg(WIDTH_ADDR, value);
            end
            if (phase_no == 0 || $urandom_range(1) == 1)
            begin
                case ($urandom_range(11))
                    0:       value = 32'd0;
                    1:       value = 32'd4096;
                    2:       value = 32'($urandom_range(4097, 8191));
                    default: value = 32'($urandom_range(1, 4));
                endcase
                write_reg(HEIGHT_ADDR, value);
            end
            run_image($urandom_range(12, 30));
            phase_no++;
        end

        calm = 1'b0;
        settle();
        if (mismatches == 0 && expected_pix.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
